// File: design/sorted_event_priority_queue_core_defines.svh
// Shared assertion macros for the sorted event queue
`ifndef SORTED_EVENT_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_EVENT_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its condition
`define SPEQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition
`define SPEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/speq_pkg.sv
package speq_pkg;

    // Operation codes carried in s_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    typedef logic [1:0] status_t;

    // Result codes carried in m_tuser
    localparam status_t ST_INSERTED = 2'd0;
    localparam status_t ST_POPPED   = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_EMPTY    = 2'd3;

    // Per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic pop;
    } speq_ctrl_t;

endpackage

// File: design/speq_cell.sv
module speq_cell
    import speq_pkg::*;
#(
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8
)
(
    input  logic                clk,
    input  speq_ctrl_t          ctrl,
    input  logic                occupied,
    input  logic [KEY_BITS-1:0] in_key,
    input  logic [TAG_BITS-1:0] in_tag,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [TAG_BITS-1:0] left_tag,
    input  logic                left_place,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic [TAG_BITS-1:0] right_tag,
    output logic [KEY_BITS-1:0] key,
    output logic [TAG_BITS-1:0] tag,
    output logic                place
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [TAG_BITS-1:0] tag_reg;
    logic [TAG_BITS-1:0] tag_next;

    // New item belongs at or ahead of this cell
    assign place = !occupied || (in_key <= key_reg);

    // Shift right on insert, take the new item at the boundary, shift left on pop
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        priority if (ctrl.ins && place)
        begin
            if (left_place)
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
            else
            begin
                key_next = in_key;
                tag_next = in_tag;
            end
        end
        else if (ctrl.pop)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
        else
        begin
            // hold
            key_next = key_reg;
            tag_next = tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

// File: design/sorted_event_priority_queue_core.sv
// An accepted item shows its result on the master side on the next cycle.
// Throughput: one insert or pop per cycle while the result register is drained;
// each item is a single compare-and-shift step across the row of cells.
// Reset: rst_n clears the entry count and the result valid flag; the stored
// keys and tags are not cleared and are only read below the entry count.
module sorted_event_priority_queue_core
    import speq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int IN_W       = KEY_BITS + TAG_BITS,
    localparam int IN_DATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = KEY_BITS + TAG_BITS + CNT_W,
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // event_key, event_tag
    input  logic                  s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_key, out_tag, occupancy
    output status_t               m_tuser    // status
);

    logic                accept;
    logic                full;
    logic                empty;
    speq_ctrl_t          ctrl;
    logic [KEY_BITS-1:0] in_key;
    logic [TAG_BITS-1:0] in_tag;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             out_status_reg;
    status_t             out_status_next;
    logic [KEY_BITS-1:0] out_key_reg;
    logic [KEY_BITS-1:0] out_key_next;
    logic [TAG_BITS-1:0] out_tag_reg;
    logic [TAG_BITS-1:0] out_tag_next;
    logic [CNT_W-1:0]    out_occ_reg;
    logic [CNT_W-1:0]    out_occ_next;

    logic [KEY_BITS-1:0] cell_key   [CAPACITY];
    logic [TAG_BITS-1:0] cell_tag   [CAPACITY];
    logic                cell_place [CAPACITY];

    // Take a new item whenever the result register is free or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign in_key = s_tdata[KEY_BITS-1:0];
    assign in_tag = s_tdata[IN_W-1:KEY_BITS];

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign ctrl.ins = accept && (s_tuser == OP_INSERT) && !full;
    assign ctrl.pop = accept && (s_tuser == OP_POP) && !empty;

    // Row of compare-and-shift cells, smallest key in cell zero
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_BITS-1:0] left_key;
        logic [TAG_BITS-1:0] left_tag;
        logic                left_place;
        logic [KEY_BITS-1:0] right_key;
        logic [TAG_BITS-1:0] right_tag;

        if (i == 0)
        begin : g_head
            assign left_key   = '0;
            assign left_tag   = '0;
            assign left_place = 1'b0;
        end
        else
        begin : g_body
            assign left_key   = cell_key[i-1];
            assign left_tag   = cell_tag[i-1];
            assign left_place = cell_place[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_key = '0;
            assign right_tag = '0;
        end
        else
        begin : g_inner
            assign right_key = cell_key[i+1];
            assign right_tag = cell_tag[i+1];
        end

        speq_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (CNT_W'(i) < count_reg),
            .in_key     (in_key),
            .in_tag     (in_tag),
            .left_key   (left_key),
            .left_tag   (left_tag),
            .left_place (left_place),
            .right_key  (right_key),
            .right_tag  (right_tag),
            .key        (cell_key[i]),
            .tag        (cell_tag[i]),
            .place      (cell_place[i])
        );
    end

    // Update the count and build the result item
    always_comb
    begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_tag_next    = out_tag_reg;
        out_occ_next    = out_occ_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            out_key_next   = '0;
            out_tag_next   = '0;
            if (ctrl.ins)
            begin
                count_next      = count_reg + CNT_W'(1);
                out_status_next = ST_INSERTED;
            end
            else if (ctrl.pop)
            begin
                count_next      = count_reg - CNT_W'(1);
                out_status_next = ST_POPPED;
                out_key_next    = cell_key[0];
                out_tag_next    = cell_tag[0];
            end
            else if (s_tuser == OP_INSERT)
            begin
                out_status_next = ST_FULL;
            end
            else
            begin
                out_status_next = ST_EMPTY;
            end
            out_occ_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_tag_reg    <= out_tag_next;
        out_occ_reg    <= out_occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_DATA_W'({out_occ_reg, out_tag_reg, out_key_reg});

endmodule

// File: design/speq_checker.sv
`include "sorted_event_priority_queue_core_defines.svh"

module speq_checker
    import speq_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int OUT_W      = KEY_BITS + TAG_BITS + CNT_W,
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8,
    localparam int KT_W       = KEY_BITS + TAG_BITS
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input status_t               m_tuser
);

    logic             stalled;
    logic             not_popped;
    logic             full_seen;
    logic [CNT_W-1:0] occ;
    logic [KT_W-1:0]  payload;

    assign stalled    = m_tvalid && !m_tready;
    assign not_popped = m_tvalid && (m_tuser != ST_POPPED);
    assign full_seen  = m_tvalid && (m_tuser == ST_FULL);
    assign occ        = m_tdata[OUT_W-1:KT_W];
    assign payload    = m_tdata[KT_W-1:0];

    // Hold a stalled result item
    `SPEQ_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata), "held result changed")

    // Accept input whenever the result register is empty
    `SPEQ_ASSERT_NOW(a_ready_free, !m_tvalid, s_tready, "input stalled with free result register")

    // Zero key and tag on every result but a pop
    `SPEQ_ASSERT_NOW(a_zero_payload, not_popped, payload == '0, "payload not zero")

    // Drop only when full
    `SPEQ_ASSERT_NOW(a_full_occ, full_seen, occ == CNT_W'(CAPACITY), "full status with room left")

    // Produce a result for every accepted item
    `SPEQ_ASSERT_NEXT(a_accept_result, s_tvalid && s_tready, m_tvalid, "accepted item gave no result")

endmodule

bind sorted_event_priority_queue_core speq_checker #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
) u_speq_checker (.*);

// File: tb/sorted_event_priority_queue_core_tb.sv
`timescale 1ns / 100ps

module sorted_event_priority_queue_core_tb;
    import speq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 10;

    // One command as offered on the slave side
    typedef struct packed {
        logic        op;
        logic [15:0] key;
        logic [7:0]  tag;
    } queue_cmd_t;

    // One result as expected on the master side
    typedef struct packed {
        status_t     status;
        logic [15:0] key;
        logic [7:0]  tag;
        logic [4:0]  occ;
    } queue_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // event_key, event_tag
    logic        s_tuser = 1'b0;   // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // out_key, out_tag, occupancy
    status_t     m_tuser;          // status

    // Shadow of the sorted row, smallest key at slot 0
    logic [15:0] key_row [QUEUE_DEPTH];
    logic [7:0]  tag_row [QUEUE_DEPTH];
    int          held = 0;

    queue_cmd_t    cmd_fifo[$];
    queue_result_t result_fifo[$];

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   rx_hold_len = 0;
    int   fail_count = 0;
    int   cycle_cnt = 0;
    logic in_taken = 1'b0;

    sorted_event_priority_queue_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Apply one insert or pop to the shadow row and return its result
    function automatic queue_result_t apply_queue_op(logic op, logic [15:0] key,
                                                     logic [7:0] tag);
        queue_result_t res;
        int            slot;
        res = '0;
        if (op == OP_INSERT)
        begin
            if (held >= QUEUE_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                // land ahead of the first key that is not smaller
                slot = 0;
                while (slot < held && key > key_row[slot])
                    slot++;
                for (int i = held; i > slot; i--)
                begin
                    key_row[i] = key_row[i-1];
                    tag_row[i] = tag_row[i-1];
                end
                key_row[slot] = key;
                tag_row[slot] = tag;
                held++;
                res.status = ST_INSERTED;
            end
        end
        else if (held == 0)
        begin
            res.status = ST_EMPTY;
        end
        else
        begin
            res.status = ST_POPPED;
            res.key = key_row[0];
            res.tag = tag_row[0];
            for (int i = 1; i < held; i++)
            begin
                key_row[i-1] = key_row[i];
                tag_row[i-1] = tag_row[i];
            end
            held--;
        end
        res.occ = held[4:0];
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Sample both handshakes: check results, then predict accepted items
    always @(posedge clk)
    begin : monitor_b
        queue_result_t want;
        in_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d data %0h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = result_fifo.pop_front();
                    check_field("status", 16'(want.status), 16'(m_tuser));
                    check_field("out_key", want.key, m_tdata[15:0]);
                    check_field("out_tag", 16'(want.tag), 16'(m_tdata[23:16]));
                    check_field("occupancy", 16'(want.occ), 16'(m_tdata[28:24]));
                    check_field("padding", 16'h0, 16'(m_tdata[31:29]));
                end
            end
            if (s_tvalid && s_tready)
                result_fifo.push_back(apply_queue_op(s_tuser, s_tdata[15:0],
                                                     s_tdata[23:16]));
        end
    end

    // Offer pending items, idling at random between them
    always @(negedge clk)
    begin : driver_b
        queue_cmd_t nxt;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (cmd_fifo.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = cmd_fifo.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= nxt.op;
                s_tdata <= {nxt.tag, nxt.key};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Drain results, with random stalls and a single long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_len > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_len <= rx_hold_len - 1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_cmd(logic op, logic [15:0] key, logic [7:0] tag);
        queue_cmd_t c;
        c.op = op;
        c.key = key;
        c.tag = tag;
        cmd_fifo.push_back(c);
    endtask

    // Random commands in bursts that lean toward filling or draining
    task automatic add_random(int count);
        int          ins_pct;
        int          pick;
        logic [15:0] key;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                pick = $urandom_range(0, 2);
                ins_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 80;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
                key = 16'h0000;
            else if (pick == 1)
                key = 16'hFFFF;
            else if (pick <= 4)
                key = 16'($urandom_range(0, 7));
            else
                key = 16'($urandom);
            add_cmd(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP, key,
                    8'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (cmd_fifo.size() != 0 || s_tvalid || result_fifo.size() != 0
               || rx_hold_len != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pop, extremes, equal keys, fill to full, full drop
        send_idle_pct = 8;
        recv_stall_pct = 81;
        add_cmd(OP_POP, 16'hFFFF, 8'hFF);
        add_cmd(OP_INSERT, 16'hFFFF, 8'hFF);
        add_cmd(OP_INSERT, 16'h0000, 8'h00);
        add_cmd(OP_INSERT, 16'h1234, 8'h01);
        add_cmd(OP_INSERT, 16'h1234, 8'h02);
        for (int i = 0; i < 12; i++)
            add_cmd(OP_INSERT, 16'h8000 ^ 16'(i * 16'h0F0F), 8'(8'h80 | i));
        add_cmd(OP_INSERT, 16'h0001, 8'hAA);
        add_cmd(OP_POP, 16'h0000, 8'h00);
        add_cmd(OP_POP, 16'h5555, 8'h55);
        add_random(430);
        wait_drained();

        send_idle_pct = 81;
        recv_stall_pct = 8;
        add_random(450);
        wait_drained();

        // Hold the receiver off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        rx_hold_len = 120;
        add_random(60);
        wait_drained();

        add_random(390);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/speq_pkg.sv
design/speq_cell.sv
design/sorted_event_priority_queue_core.sv
design/speq_checker.sv
tb/sorted_event_priority_queue_core_tb.sv
